>>> rtl/fbpa_pkg.sv
package fbpa_pkg;

	localparam int ADDR_W = 48;
	localparam int SIZE_W = 17;
	localparam int CAP_W  = 9;
	localparam int STAT_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_WRONG_SIZE = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
	localparam logic [STAT_W-1:0] ST_NULL       = 3'd3;
	localparam logic [STAT_W-1:0] ST_RANGE      = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_IN_USE = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BSIZE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

	localparam logic [ADDR_W-1:0] BASE_RESET  = 48'd4096;
	localparam logic [SIZE_W-1:0] BSIZE_RESET = 17'd64;
	localparam logic [CAP_W-1:0]  CAP_RESET   = 9'd256;

	// one quotient bit per step
	localparam int DIV_STEPS = ADDR_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/fbpa_bitmap.sv
module fbpa_bitmap #(
	parameter int DEPTH = 256,
	parameter int IW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic          wdata,
	input  logic [IW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/fbpa_divider.sv
module fbpa_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  fbpa_pkg::div_req_t  req,
	output fbpa_pkg::div_rsp_t  rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [fbpa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [fbpa_pkg::SIZE_W-1:0]   rem_q;
	logic [fbpa_pkg::ADDR_W-1:0]   quo_q;
	logic [fbpa_pkg::SIZE_W-1:0]   dvs_q;
	logic [fbpa_pkg::SIZE_W:0]     shifted;
	logic [fbpa_pkg::SIZE_W+1:0]   diff;
	logic                          ge;

	// restoring step: shift in next dividend bit, try subtract
	assign shifted = {rem_q, quo_q[fbpa_pkg::ADDR_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = ~diff[fbpa_pkg::SIZE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[fbpa_pkg::SIZE_W-1:0] : shifted[fbpa_pkg::SIZE_W-1:0];
			quo_q <= {quo_q[fbpa_pkg::ADDR_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// fixed-size block pool allocator
//
// s_* channel: one request per transfer. s_tuser carries the opcode
// (0 acquire, 1 release), s_tdata the requested size and the address
// handed back. m_* channel: exactly one result per request, carrying a
// status code and the acquired block address (zero unless an acquire
// succeeded). cfg_we/cfg_index/cfg_wdata write base address, block size
// and capacity; write them only while no request is in flight.
//
// one request is processed at a time under a small sequencer. an acquire
// checks the cached free index, then runs an upward scan of the bitmap
// for the next free block (one bitmap read per SCAN_RD/SCAN_CHK pass).
// a release waits on the bit-serial divider that turns the address
// offset into a block index (48 steps). early rejects (wrong size, full,
// null, below base, zero block size) go straight to the result.
//
// after reset the bitmap memory is swept to all free, one entry per
// cycle, with s_tready low. the result sits in an output register: a new
// request may be taken while it waits, but a finished result holds the
// sequencer until m_tready drains the register.
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [16:0] request_size, [64:17] release_address, [71:65] zero
	input  logic [71:0] s_tdata,
	// [0] opcode
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] status, [50:3] block_address, [55:51] zero
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_wdata
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = (CW > fbpa_pkg::CAP_W) ? CW : fbpa_pkg::CAP_W;
	localparam int PW = IW + fbpa_pkg::SIZE_W;
	localparam int AW = fbpa_pkg::ADDR_W;
	localparam int SW = fbpa_pkg::SIZE_W;

	typedef enum logic [3:0] {
		CLEAR,
		IDLE,
		ACQ_RD,
		ACQ_CHK,
		ACQ_ADDR,
		SCAN_RD,
		SCAN_CHK,
		REL_CHK,
		REL_DIV,
		REL_RD,
		REL_CHK2,
		FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [AW-1:0]               base_q;
	logic [SW-1:0]               bsize_q;
	logic [fbpa_pkg::CAP_W-1:0]  cap_q;

	// allocator state
	logic [IW-1:0] lfi_q;
	logic          lfv_q;
	logic [IW-1:0] clr_q;
	logic [CW-1:0] scan_q;
	logic [IW-1:0] slot_q;
	logic [PW-1:0] prod_q;

	// captured request
	logic [SW-1:0] req_size_q;
	logic [AW-1:0] rel_addr_q;

	// pending result and output register
	logic [fbpa_pkg::STAT_W-1:0] res_stat_q;
	logic [AW-1:0]               res_addr_q;
	logic                        m_valid_q;
	logic [fbpa_pkg::STAT_W-1:0] m_stat_q;
	logic [AW-1:0]               m_addr_q;

	// effective capacity: min(capacity, MAX_BLOCKS)
	logic [EW-1:0] cap_ext;
	logic [EW-1:0] maxb_ext;
	logic [CW-1:0] cap_eff;

	assign cap_ext  = EW'(cap_q);
	assign maxb_ext = EW'(MAX_BLOCKS);
	assign cap_eff  = (cap_ext < maxb_ext) ? cap_ext[CW-1:0] : maxb_ext[CW-1:0];

	// bitmap memory port
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic          mem_rdata;

	fbpa_pkg::div_req_t div_req;
	fbpa_pkg::div_rsp_t div_rsp;

	fbpa_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fbpa_bitmap #(
		.DEPTH (MAX_BLOCKS),
		.IW    (IW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	logic s_fire;
	logic out_free;
	logic quo_in_range;

	assign s_tready     = (state_q == IDLE);
	assign s_fire       = s_tvalid && s_tready;
	assign out_free     = !m_valid_q || m_tready;
	assign quo_in_range = div_rsp.quotient < AW'(cap_eff);

	// divider launch: offset from base over block size
	assign div_req.start    = (state_q == REL_CHK) && (rel_addr_q != '0) &&
	                          (rel_addr_q >= base_q) && (bsize_q != '0);
	assign div_req.dividend = rel_addr_q - base_q;
	assign div_req.divisor  = bsize_q;

	// bitmap access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lfi_q;
		mem_wdata = 1'b0;
		mem_raddr = lfi_q;
		unique case (state_q)
			CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 1'b0;
			end
			ACQ_CHK: begin
				mem_we    = !mem_rdata;
				mem_waddr = lfi_q;
				mem_wdata = 1'b1;
			end
			SCAN_RD: begin
				mem_raddr = scan_q[IW-1:0];
			end
			REL_RD: begin
				mem_raddr = div_rsp.quotient[IW-1:0];
			end
			REL_CHK2: begin
				mem_we    = mem_rdata;
				mem_waddr = slot_q;
				mem_wdata = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= fbpa_pkg::BASE_RESET;
			bsize_q <= fbpa_pkg::BSIZE_RESET;
			cap_q   <= fbpa_pkg::CAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fbpa_pkg::CFG_BASE:     base_q  <= cfg_wdata;
				fbpa_pkg::CFG_BSIZE:    bsize_q <= cfg_wdata[SW-1:0];
				fbpa_pkg::CFG_CAPACITY: cap_q   <= cfg_wdata[fbpa_pkg::CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, allocator state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CLEAR;
			lfi_q      <= '0;
			lfv_q      <= 1'b1;
			clr_q      <= '0;
			scan_q     <= '0;
			slot_q     <= '0;
			prod_q     <= '0;
			req_size_q <= '0;
			rel_addr_q <= '0;
			res_stat_q <= fbpa_pkg::ST_OK;
			res_addr_q <= '0;
			m_valid_q  <= 1'b0;
			m_stat_q   <= fbpa_pkg::ST_OK;
			m_addr_q   <= '0;
		end else begin
			// drained and not refilled this cycle
			if (m_valid_q && m_tready && !((state_q == FIN) && out_free)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(MAX_BLOCKS - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_fire) begin
						req_size_q <= s_tdata[SW-1:0];
						rel_addr_q <= s_tdata[SW+AW-1:SW];
						res_stat_q <= fbpa_pkg::ST_OK;
						res_addr_q <= '0;
						state_q    <= s_tuser[0] ? REL_CHK : ACQ_RD;
					end
				end
				ACQ_RD: begin
					if (req_size_q != bsize_q) begin
						res_stat_q <= fbpa_pkg::ST_WRONG_SIZE;
						state_q    <= FIN;
					end else if (!lfv_q || (CW'(lfi_q) >= cap_eff)) begin
						res_stat_q <= fbpa_pkg::ST_FULL;
						state_q    <= FIN;
					end else begin
						state_q <= ACQ_CHK;
					end
				end
				ACQ_CHK: begin
					if (mem_rdata) begin
						// stale index names a block in use
						res_stat_q <= fbpa_pkg::ST_FULL;
						state_q    <= FIN;
					end else begin
						prod_q  <= PW'(lfi_q) * PW'(bsize_q);
						slot_q  <= lfi_q;
						scan_q  <= CW'(lfi_q) + 1'b1;
						lfi_q   <= '0;
						lfv_q   <= 1'b0;
						state_q <= ACQ_ADDR;
					end
				end
				ACQ_ADDR: begin
					res_addr_q <= base_q + AW'(prod_q);
					state_q    <= SCAN_RD;
				end
				SCAN_RD: begin
					if (scan_q >= cap_eff) begin
						state_q <= FIN;
					end else begin
						state_q <= SCAN_CHK;
					end
				end
				SCAN_CHK: begin
					if (!mem_rdata) begin
						lfi_q   <= scan_q[IW-1:0];
						lfv_q   <= 1'b1;
						state_q <= FIN;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= SCAN_RD;
					end
				end
				REL_CHK: begin
					if (rel_addr_q == '0) begin
						res_stat_q <= fbpa_pkg::ST_NULL;
						state_q    <= FIN;
					end else if ((rel_addr_q < base_q) || (bsize_q == '0)) begin
						res_stat_q <= fbpa_pkg::ST_RANGE;
						state_q    <= FIN;
					end else begin
						state_q <= REL_DIV;
					end
				end
				REL_DIV: begin
					if (div_rsp.done) begin
						state_q <= REL_RD;
					end
				end
				REL_RD: begin
					if (!quo_in_range) begin
						res_stat_q <= fbpa_pkg::ST_RANGE;
						state_q    <= FIN;
					end else begin
						slot_q  <= div_rsp.quotient[IW-1:0];
						state_q <= REL_CHK2;
					end
				end
				REL_CHK2: begin
					if (!mem_rdata) begin
						res_stat_q <= fbpa_pkg::ST_NOT_IN_USE;
					end else if (!lfv_q || (slot_q < lfi_q)) begin
						lfi_q <= slot_q;
						lfv_q <= 1'b1;
					end
					state_q <= FIN;
				end
				FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_stat_q  <= res_stat_q;
						m_addr_q  <= res_addr_q;
						state_q   <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b00000, m_addr_q, m_stat_q};

endmodule
